// ===== rtl/wsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard substring match: shared definitions
// Sizes, register indexes, beat payload types and the control struct that
// drives the row of match cells.
// ----------------------------------------------------------------------------
package wsm_pkg;

   // Longest pattern the block supports, and the bytes the pattern registers hold.
   localparam int PATTERN_MAX = 16;
   localparam int REG_BYTES   = 16;

   // One cell per pattern byte that can be in use.
   localparam int NUM_CELLS = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

   // Width of a length in use (0 to NUM_CELLS).
   localparam int LEN_W = $clog2(NUM_CELLS + 1);

   // Width of the pattern length register.
   localparam int PLEN_W = 5;

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   // Pattern byte that matches any text byte.
   localparam logic [7:0] WILDCARD = 8'd63;

   // Pattern byte that ends the pattern early.
   localparam logic [7:0] NUL_BYTE = 8'd0;

   // Input beat payload.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   // Result beat payload.
   typedef struct packed {
      logic found;
      logic string_done;
   } rsp_type;

   // Per-cycle control shared by every cell in the row.
   typedef struct packed {
      logic step;   // a text byte advances the partial matches
      logic clear;  // a terminator wipes the partial matches
   } cell_ctrl_type;

   // Pattern bytes as presented to the cells.
   typedef logic [NUM_CELLS-1:0][7:0] pattern_type;

endpackage

// ===== rtl/wsm_cfg.sv =====
// ----------------------------------------------------------------------------
// Wildcard substring match: configuration registers
// Holds the pattern bytes and length, and keeps the length in use (length
// saturated to the cell count and cut at the first zero byte) in a register
// that is updated in the same cycle as the write.
// ----------------------------------------------------------------------------
module wsm_cfg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [wsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output wsm_pkg::pattern_type          pattern,
   output logic [wsm_pkg::LEN_W-1:0]      used_len
);
   import wsm_pkg::*;

   logic [63:0]       pat_low_ff,  pat_low_in;
   logic [63:0]       pat_high_ff, pat_high_in;
   logic [PLEN_W-1:0] plen_ff,     plen_in;
   logic [LEN_W-1:0]  len_ff,      len_in;
   logic [127:0]      pat_all;

   // Length in use: saturate, then stop at the first zero byte inside it.
   function automatic logic [LEN_W-1:0] calc_used_len(
      input logic [63:0]       lo,
      input logic [63:0]       hi,
      input logic [PLEN_W-1:0] plen
   );
      logic [127:0]      all_bytes;
      logic [PLEN_W-1:0] sat;
      logic [LEN_W-1:0]  result;
      all_bytes = {hi, lo};
      sat = (plen > PLEN_W'(NUM_CELLS)) ? PLEN_W'(NUM_CELLS) : plen;
      result = LEN_W'(sat);
      for (int i = NUM_CELLS - 1; i >= 0; i--) begin
         if ((PLEN_W'(i) < sat) && (all_bytes[8*i +: 8] == NUL_BYTE)) begin
            result = LEN_W'(i);
         end
      end
      return result;
   endfunction

   // Register write decode.
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      plen_in     = plen_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_in  = csr_wdata;
            CSR_PATTERN_HIGH: pat_high_in = csr_wdata;
            CSR_PATTERN_LEN:  plen_in     = csr_wdata[PLEN_W-1:0];
            default:          ;
         endcase
      end
      len_in = calc_used_len(pat_low_in, pat_high_in, plen_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         plen_ff     <= '0;
         len_ff      <= '0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         plen_ff     <= plen_in;
         len_ff      <= len_in;
      end
   end

   // Present the bytes the cells use.
   assign pat_all = {pat_high_ff, pat_low_ff};

   always_comb begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         pattern[i] = pat_all[8*i +: 8];
      end
   end

   assign used_len = len_ff;

endmodule

// ===== rtl/wsm_cell.sv =====
// ----------------------------------------------------------------------------
// Wildcard substring match: match cell
// Holds one bit of the partial-match vector. On each text byte it takes the
// bit of its left neighbor, keeps it if its pattern byte matches, and hands
// the result on to its right neighbor in the next cycle.
// ----------------------------------------------------------------------------
module wsm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wsm_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             text_byte,
   input  logic [7:0]             pattern_byte,
   input  logic                   in_use,
   input  logic                   is_last,
   input  logic                   prev_match,
   output logic                   match,
   output logic                   hit
);
   import wsm_pkg::*;

   logic match_ff, match_in;
   logic byte_ok;

   // The pattern byte accepts this text byte.
   assign byte_ok = in_use && ((pattern_byte == WILDCARD) || (pattern_byte == text_byte));

   // Prefix through this cell matches the text ending at this byte.
   always_comb begin
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.step) begin
         match_in = prev_match && byte_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   // The last cell in use reports a whole-pattern match.
   assign hit   = ctrl.step && is_last && prev_match && byte_ok;
   assign match = match_ff;

endmodule

// ===== rtl/wildcard_substring_match.sv =====
// ----------------------------------------------------------------------------
// Wildcard substring match
// Searches a byte stream for a configured pattern with single-byte wildcards.
// ----------------------------------------------------------------------------
// The block takes one text byte or terminator beat every clock cycle and
// returns one result beat per input beat in the next cycle, through an output
// register; req_ready drops only while that register holds a result that
// rsp_ready has not taken. The rate is set by the row of match cells, one per
// pattern byte, which all update their partial-match bit in the same cycle.
// Pattern writes take effect on the next input beat; there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module wildcard_substring_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wsm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wsm_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [wsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wsm_pkg::*;

   pattern_type          pattern;
   logic [LEN_W-1:0]     used_len;
   logic                 len_zero;
   logic                 req_accept;
   cell_ctrl_type        ctrl;
   logic [NUM_CELLS-1:0] match_vec;
   logic [NUM_CELLS-1:0] hit_vec;
   logic [NUM_CELLS:0]   chain;
   logic                 found_now;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Configuration registers and length in use.
   wsm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pattern   (pattern),
      .used_len  (used_len)
   );

   assign len_zero   = (used_len == '0);
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Text bytes advance the cells; a terminator clears them.
   assign ctrl.step  = req_accept && !req_data.end_of_text && !len_zero;
   assign ctrl.clear = req_accept && req_data.end_of_text;

   // Row of cells; the first cell always sees a matching empty prefix.
   assign chain[0] = 1'b1;
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      wsm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .text_byte    (req_data.text_byte),
         .pattern_byte (pattern[i]),
         .in_use       (LEN_W'(i) < used_len),
         .is_last      (LEN_W'(i + 1) == used_len),
         .prev_match   (chain[i]),
         .match        (match_vec[i]),
         .hit          (hit_vec[i])
      );
      assign chain[i+1] = match_vec[i];
   end

   // Sticky found flag, cleared after the terminator is reported.
   assign found_now = found_ff || len_zero || (|hit_vec);

   always_comb begin
      found_in = found_ff;
      if (req_accept) begin
         found_in = req_data.end_of_text ? 1'b0 : found_now;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.found       = found_now;
         rsp_data_in.string_done = req_data.end_of_text;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A terminator leaves no partial match and no found flag behind.
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.end_of_text |=> (match_vec == '0) && !found_ff)
      else $error("partial matches survive a terminator");

   // Every accepted beat has a result waiting in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

   // An empty pattern reports found on every result.
   a_empty_found: assert property (@(posedge clock) disable iff (reset)
      req_accept && len_zero |=> rsp_data_ff.found)
      else $error("empty pattern not reported as found");

   // The result carries the terminator marker of its beat.
   a_done_marker: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_data_ff.string_done == $past(req_data.end_of_text)))
      else $error("string_done does not follow the terminator");

endmodule

// ===== dv/wildcard_substring_match_test.sv =====
// ----------------------------------------------------------------------------
// Wildcard substring match: self-checking testbench
// Streams strings of text bytes into the block under a series of pattern
// settings. A shift-and predictor works out the found flag for every beat.
// The testbench begins with a short table of hand-picked beats and register
// writes, then runs random phases with idle gaps and receiver stalls, one of
// them with long receiver hold-offs. Every result beat is compared with the
// oldest expected result, predicted or taken from the table.
// ----------------------------------------------------------------------------
module wildcard_substring_match_test;
   import wsm_pkg::*;

   localparam int WATCHDOG_CYCLES = 1000;
   localparam int HOLD_CYCLES     = 60;
   localparam int PHASE_BEATS     = 100;
   localparam int NUM_PHASES      = 8;
   localparam int SETTLE_CYCLES   = 4;
   localparam int MAX_REPORTS     = 10;

   // Register index past the end of the list; writes to it are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_C = 8'h63;
   localparam logic [7:0] CHAR_Q = 8'h71;
   localparam logic [7:0] CHAR_X = 8'h78;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      req_type               beat;
      bit                    known;
      rsp_type               want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor copy of the registers and the search state.
   logic [63:0]           pattern_lo;
   logic [63:0]           pattern_hi;
   logic [PLEN_W-1:0]     pattern_len;
   logic [NUM_CELLS-1:0]  run_vec;
   logic                  hit_flag;

   // Result beats still owed by the block, oldest first.
   rsp_type               flags_due[$];
   plan_row_type          plan[$];

   // Side information for the beat currently offered.
   bit                    beat_known;
   rsp_type               beat_want;

   int                    tx_idle_pct;
   int                    rx_stall_pct;
   bit                    hold_req;
   int                    hold_left;
   int                    fail_count;
   int                    quiet_cycles;
   bit                    moved;
   rsp_type               oldest;
   rsp_type               predicted;

   wildcard_substring_match dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the shift-and search by one beat and return the result it owes.
   function automatic rsp_type match_step(input req_type beat);
      logic [127:0]         all_pat;
      logic [NUM_CELLS-1:0] eq;
      rsp_type              res;
      int                   n;
      int                   i;
      all_pat = {pattern_hi, pattern_lo};
      n = pattern_len;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      if (n > REG_BYTES) n = REG_BYTES;
      // A zero byte ends the pattern early.
      for (i = n - 1; i >= 0; i--) begin
         if (all_pat[8*i +: 8] == NUL_BYTE) n = i;
      end
      if (n == 0) hit_flag = 1'b1;
      if (beat.end_of_text) begin
         res.found       = hit_flag;
         res.string_done = 1'b1;
         hit_flag = 1'b0;
         run_vec  = '0;
         return res;
      end
      if (n != 0) begin
         eq = '0;
         for (i = 0; i < n; i++) begin
            if (all_pat[8*i +: 8] == WILDCARD || all_pat[8*i +: 8] == beat.text_byte)
               eq[i] = 1'b1;
         end
         run_vec = ((run_vec << 1) | NUM_CELLS'(1)) & eq;
         if (run_vec[n-1]) hit_flag = 1'b1;
      end
      res.found       = hit_flag;
      res.string_done = 1'b0;
      return res;
   endfunction

   function automatic void add_beat(input logic [7:0] text, input logic eot, input bit known,
                                    input logic found, input logic done);
      plan_row_type row;
      row.kind             = ROW_BEAT;
      row.index            = '0;
      row.wdata            = '0;
      row.beat.text_byte   = text;
      row.beat.end_of_text = eot;
      row.known            = known;
      row.want.found       = found;
      row.want.string_done = done;
      plan.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] wdata);
      plan_row_type row;
      row.kind  = ROW_CSR;
      row.index = index;
      row.wdata = wdata;
      row.beat  = '0;
      row.known = 1'b0;
      row.want  = '0;
      plan.push_back(row);
   endfunction

   // Text bytes lean on a small alphabet so that patterns hit often.
   function automatic logic [7:0] random_text();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) return CHAR_A;
      if (pick < 60) return CHAR_B;
      if (pick < 65) return CHAR_C;
      if (pick < 80) return 8'hFF;
      if (pick < 88) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [127:0] random_pattern();
      logic [127:0] pat;
      int           i;
      int           pick;
      for (i = 0; i < 16; i++) begin
         pick = $urandom_range(9);
         if (pick < 4) pat[8*i +: 8] = CHAR_A;
         else if (pick < 7) pat[8*i +: 8] = CHAR_B;
         else if (pick < 9) pat[8*i +: 8] = WILDCARD;
         else pat[8*i +: 8] = 8'($urandom_range(1, 255));
      end
      return pat;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endfunction

   // Offer one beat, with random idle cycles first, and hold it until taken.
   task automatic drive_beat(input req_type beat, input bit known, input rsp_type want);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data   = beat;
      beat_known = known;
      beat_want  = want;
      req_valid  = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Let every owed result drain, then give the block a few spare cycles.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (flags_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] wdata);
      req_valid = 1'b0;
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = wdata;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Monitor: track register writes, predict accepted beats, check results.
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_LOW: begin
                  pattern_lo = csr_wdata;
               end
               CSR_PATTERN_HIGH: begin
                  pattern_hi = csr_wdata;
               end
               CSR_PATTERN_LEN: begin
                  pattern_len = csr_wdata[PLEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (flags_due.size() == 0) begin
               note_failure("result beat with nothing expected");
            end else begin
               oldest = flags_due.pop_front();
               if (rsp_data.found !== oldest.found)
                  note_failure($sformatf("found expected %b, got %b",
                                         oldest.found, rsp_data.found));
               if (rsp_data.string_done !== oldest.string_done)
                  note_failure($sformatf("string_done expected %b, got %b",
                                         oldest.string_done, rsp_data.string_done));
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            predicted = match_step(req_data);
            flags_due.push_back(beat_known ? beat_want : predicted);
         end
         // Watchdog on stretches with no beat moving on either side.
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("[wildcard_substring_match] ERROR");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type          row;
      req_type               beat;
      rsp_type               none;
      logic [127:0]          pat;
      int                    len;
      int                    p;
      int                    k;
      int                    sent;
      int                    run_len;
      idle_mode_type         mode;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      beat_known   = 1'b0;
      beat_want    = '0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_req     = 1'b0;
      fail_count   = 0;
      quiet_cycles = 0;
      pattern_lo   = '0;
      pattern_hi   = '0;
      pattern_len  = '0;
      run_vec      = '0;
      hit_flag     = 1'b0;
      none         = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Empty pattern after reset: every beat reports found, empty string too.
      add_beat(CHAR_A, 1'b0, 1'b1, 1'b1, 1'b0);
      add_beat(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
      add_beat(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
      // Pattern "ab?" with a trailing wildcard that must still match a byte.
      add_csr(CSR_PATTERN_LOW, 64'hFFFF_FFFF_FF3F_6261);
      add_csr(CSR_PATTERN_HIGH, '1);
      add_csr(CSR_PATTERN_LEN, 64'd3);
      add_csr(CSR_SPARE, 64'h0123_4567_89AB_CDEF);
      add_beat(CHAR_X, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(CHAR_A, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(CHAR_B, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(CHAR_C, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      // Text shorter than the pattern never matches.
      add_beat(CHAR_A, 1'b0, 1'b1, 1'b0, 1'b0);
      add_beat(CHAR_B, 1'b0, 1'b1, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b1, 1'b0, 1'b1);
      // Shorten the pattern mid-string; the partial matches carry over.
      add_beat(CHAR_A, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(CHAR_B, 1'b0, 1'b0, 1'b0, 1'b0);
      add_csr(CSR_PATTERN_LEN, 64'd2);
      add_beat(CHAR_B, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      // A zero byte cuts the pattern to "q" despite a length of 16.
      add_csr(CSR_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_0071);
      add_csr(CSR_PATTERN_LEN, 64'd16);
      add_beat(CHAR_Q, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      // Length beyond the limit saturates to 16 wildcards.
      add_csr(CSR_PATTERN_LOW, 64'h3F3F_3F3F_3F3F_3F3F);
      add_csr(CSR_PATTERN_HIGH, 64'h3F3F_3F3F_3F3F_3F3F);
      add_csr(CSR_PATTERN_LEN, 64'd31);
      add_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.index, row.wdata);
         end else begin
            drive_beat(row.beat, row.known, row.want);
         end
      end

      // Random phases: a fresh pattern setting and idle mode for each.
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         pat = random_pattern();
         len = $urandom_range(1, 16);
         case (p)
            0: begin
               pat = '0;
               len = 0;
            end
            1: begin
               len = 16;
            end
            2: begin
               len = 31;
            end
            3: begin
               pat = '1;
            end
            5: begin
               pat[8*$urandom_range(0, 15) +: 8] = NUL_BYTE;
               len = $urandom_range(1, 31);
            end
            6, 7: begin
               len = $urandom_range(0, 31);
               if ($urandom_range(3) == 0) pat = {$urandom, $urandom, $urandom, $urandom};
            end
            default: begin
               len = $urandom_range(1, 4);
            end
         endcase
         write_csr(CSR_PATTERN_LOW, pat[63:0]);
         write_csr(CSR_PATTERN_HIGH, pat[127:64]);
         write_csr(CSR_PATTERN_LEN, CSR_DATA_W'(len));

         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_SENDER: begin
               tx_idle_pct  = 54;
               rx_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 54;
            end
            IDLE_BOTH: begin
               tx_idle_pct  = 25;
               rx_stall_pct = 25;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
         endcase
         // Phase 4 runs flat out against long receiver hold-offs.
         if (p == 4) hold_req = 1'b1;

         sent = 0;
         while (sent < PHASE_BEATS) begin
            run_len = $urandom_range(0, 20);
            if ($urandom_range(9) == 0) run_len = $urandom_range(20, 40);
            for (k = 0; k < run_len; k++) begin
               beat.text_byte   = random_text();
               beat.end_of_text = 1'b0;
               drive_beat(beat, 1'b0, none);
               sent++;
               if (p == 4 && sent == PHASE_BEATS / 2) hold_req = 1'b1;
            end
            // Most strings end here; the rest run on into the next string.
            if ($urandom_range(99) < 85) begin
               beat.text_byte   = 8'($urandom_range(255));
               beat.end_of_text = 1'b1;
               drive_beat(beat, 1'b0, none);
               sent++;
            end
         end
      end

      req_valid = 1'b0;
      while (flags_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("[wildcard_substring_match] OK");
      else
         $display("[wildcard_substring_match] ERROR");
      $finish;
   end

endmodule
